>>> design/dstq_pkg.sv
// ----------------------------------------------------------------------------
// dstq_pkg
// Shared types and constants for the deadline-sorted timer queue.
// ----------------------------------------------------------------------------
package dstq_pkg;

    // Table geometry
    localparam int MAX_TIMERS   = 16;
    localparam int RESULT_LIMIT = 16;
    localparam int IDX_W        = $clog2(MAX_TIMERS);
    localparam int CNT_W        = $clog2(MAX_TIMERS + 1);

    // Commands
    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_ADJUST = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_TICK   = 2'd3
    } t_cmd;

    // Result status codes
    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_EXPIRED   = 3'd1,
        ST_NONE_DUE  = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_PRESENT   = 3'd5
    } t_status;

    // Input item
    typedef struct packed {
        t_cmd        command;
        logic [3:0]  timer_id;
        logic [31:0] deadline;
        logic [31:0] now;
    } t_in_item;

    // Result item
    typedef struct packed {
        t_status    status;
        logic [3:0] expired_id;
        logic       last;
    } t_out_item;

    // One table entry
    typedef struct packed {
        logic [31:0] deadline;
        logic [3:0]  ident;
    } t_entry;

    // Memory port request
    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] raddr;
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
    } t_ram_req;

    // Result hand-off from the sequencer to the output register
    typedef struct packed {
        logic      valid;
        t_out_item res;
    } t_emit;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SETUP_UP,
        S_MOVE,
        S_WRITE_NEW,
        S_RESP,
        S_TREAD,
        S_TEVAL,
        S_TEND
    } t_seq_state;

endpackage

>>> design/dstq_ram.sv
// ----------------------------------------------------------------------------
// dstq_ram
// Timer table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dstq_ram import dstq_pkg::*; (
    input  logic     i_clk,
    input  t_ram_req i_req,
    output t_entry   o_rd_data
);

    t_entry mem [MAX_TIMERS];
    t_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // read port, data held between reads
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_data <= mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/dstq_seq.sv
// ----------------------------------------------------------------------------
// dstq_seq
// Command sequencer: scans the table, shifts entries in memory and issues
// results one at a time.
// ----------------------------------------------------------------------------
module dstq_seq import dstq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_in_item i_item,
    input  logic     i_can_load,
    input  t_entry   i_rd_data,
    output t_ram_req o_ram_req,
    output t_emit    o_emit,
    output logic     o_busy
);

    t_seq_state       r_state, n_state;
    t_in_item         r_item, n_item;
    logic [CNT_W-1:0] r_count, n_count;
    // scan
    logic [CNT_W-1:0] r_s, n_s;
    logic             r_ev, n_ev;
    logic [IDX_W-1:0] r_ev_idx, n_ev_idx;
    logic             r_found, n_found;
    logic [IDX_W-1:0] r_match, n_match;
    logic [CNT_W-1:0] r_le, n_le;
    // move engine
    logic [CNT_W-1:0] r_src, n_src;
    logic [CNT_W-1:0] r_dst, n_dst;
    logic [CNT_W-1:0] r_left, n_left;
    logic             r_up, n_up;
    logic             r_wv, n_wv;
    logic [IDX_W-1:0] r_wa, n_wa;
    // tick and response
    logic             r_pend, n_pend;
    logic [3:0]       r_pend_id, n_pend_id;
    t_status          r_status, n_status;

    logic             issue;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ev    <= 1'b0;
            r_wv    <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ev    <= n_ev;
            r_wv    <= n_wv;
            r_pend  <= n_pend;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_s       <= n_s;
        r_ev_idx  <= n_ev_idx;
        r_found   <= n_found;
        r_match   <= n_match;
        r_le      <= n_le;
        r_src     <= n_src;
        r_dst     <= n_dst;
        r_left    <= n_left;
        r_up      <= n_up;
        r_wa      <= n_wa;
        r_pend_id <= n_pend_id;
        r_status  <= n_status;
    end

    // next state and outputs
    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_count   = r_count;
        n_s       = r_s;
        n_ev      = 1'b0;
        n_ev_idx  = r_ev_idx;
        n_found   = r_found;
        n_match   = r_match;
        n_le      = r_le;
        n_src     = r_src;
        n_dst     = r_dst;
        n_left    = r_left;
        n_up      = r_up;
        n_wv      = 1'b0;
        n_wa      = r_wa;
        n_pend    = r_pend;
        n_pend_id = r_pend_id;
        n_status  = r_status;
        issue     = 1'b0;
        o_ram_req = '0;
        o_emit    = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_item  = i_item;
                    n_s     = '0;
                    n_found = 1'b0;
                    n_le    = '0;
                    n_pend  = 1'b0;
                    if (i_item.command == CMD_TICK) begin
                        n_state = S_TREAD;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            // one read per cycle, evaluated the cycle after
            S_SCAN: begin
                issue = (r_s < r_count);
                o_ram_req.re    = issue;
                o_ram_req.raddr = r_s[IDX_W-1:0];
                n_ev     = issue;
                n_ev_idx = r_s[IDX_W-1:0];
                if (issue) begin
                    n_s = r_s + 1'b1;
                end
                if (r_ev) begin
                    if (i_rd_data.ident == r_item.timer_id) begin
                        n_found = 1'b1;
                        n_match = r_ev_idx;
                    end else if (i_rd_data.deadline <= r_item.deadline) begin
                        n_le = r_le + 1'b1;
                    end
                end
                if (!issue && !r_ev) begin
                    n_state = S_DECIDE;
                end
            end

            S_DECIDE: begin
                if (r_item.command == CMD_ADD) begin
                    if (r_found) begin
                        n_status = ST_PRESENT;
                        n_state  = S_RESP;
                    end else if (r_count >= CNT_W'(MAX_TIMERS)) begin
                        n_status = ST_FULL;
                        n_state  = S_RESP;
                    end else begin
                        n_state = S_SETUP_UP;
                    end
                end else if (!r_found) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_RESP;
                end else begin
                    // close the gap left by the matched entry
                    n_src   = CNT_W'(r_match) + 1'b1;
                    n_dst   = CNT_W'(r_match);
                    n_left  = r_count - 1'b1 - CNT_W'(r_match);
                    n_up    = 1'b0;
                    n_count = r_count - 1'b1;
                    n_state = S_MOVE;
                end
            end

            // open a gap at the insertion slot
            S_SETUP_UP: begin
                n_src   = r_count - 1'b1;
                n_dst   = r_count;
                n_left  = r_count - r_le;
                n_up    = 1'b1;
                n_state = S_MOVE;
            end

            // pipelined copy: read source, write destination next cycle
            S_MOVE: begin
                issue = (r_left != '0);
                o_ram_req.re    = issue;
                o_ram_req.raddr = r_src[IDX_W-1:0];
                o_ram_req.we    = r_wv;
                o_ram_req.waddr = r_wa;
                o_ram_req.wdata = i_rd_data;
                n_wv = issue;
                n_wa = r_dst[IDX_W-1:0];
                if (issue) begin
                    n_left = r_left - 1'b1;
                    if (r_up) begin
                        n_src = r_src - 1'b1;
                        n_dst = r_dst - 1'b1;
                    end else begin
                        n_src = r_src + 1'b1;
                        n_dst = r_dst + 1'b1;
                    end
                end
                if (!issue && !r_wv) begin
                    if (r_up) begin
                        n_state = S_WRITE_NEW;
                    end else begin
                        case (r_item.command)
                            CMD_ADJUST: n_state = S_SETUP_UP;
                            CMD_DELETE: begin
                                n_status = ST_DONE;
                                n_state  = S_RESP;
                            end
                            default:    n_state = S_IDLE;
                        endcase
                    end
                end
            end

            S_WRITE_NEW: begin
                o_ram_req.we             = 1'b1;
                o_ram_req.waddr          = r_le[IDX_W-1:0];
                o_ram_req.wdata.deadline = r_item.deadline;
                o_ram_req.wdata.ident    = r_item.timer_id;
                n_count  = r_count + 1'b1;
                n_status = ST_DONE;
                n_state  = S_RESP;
            end

            S_RESP: begin
                o_emit.valid          = 1'b1;
                o_emit.res.status     = r_status;
                o_emit.res.expired_id = '0;
                o_emit.res.last       = 1'b1;
                if (i_can_load) begin
                    n_state = S_IDLE;
                end
            end

            // tick: read the next front entry
            S_TREAD: begin
                if ((r_s < r_count) && (32'(r_s) < RESULT_LIMIT)) begin
                    o_ram_req.re    = 1'b1;
                    o_ram_req.raddr = r_s[IDX_W-1:0];
                    n_state = S_TEVAL;
                end else begin
                    n_state = S_TEND;
                end
            end

            // a due timer is held back one step so the last flag is known
            S_TEVAL: begin
                if (i_rd_data.deadline <= r_item.now) begin
                    if (r_pend) begin
                        o_emit.valid          = 1'b1;
                        o_emit.res.status     = ST_EXPIRED;
                        o_emit.res.expired_id = r_pend_id;
                        o_emit.res.last       = 1'b0;
                    end
                    if (!r_pend || i_can_load) begin
                        n_pend    = 1'b1;
                        n_pend_id = i_rd_data.ident;
                        n_s       = r_s + 1'b1;
                        n_state   = S_TREAD;
                    end
                end else begin
                    n_state = S_TEND;
                end
            end

            // final tick result, then drop the expired prefix
            S_TEND: begin
                o_emit.valid          = 1'b1;
                o_emit.res.status     = r_pend ? ST_EXPIRED : ST_NONE_DUE;
                o_emit.res.expired_id = r_pend ? r_pend_id : 4'd0;
                o_emit.res.last       = 1'b1;
                if (i_can_load) begin
                    n_pend  = 1'b0;
                    n_src   = r_s;
                    n_dst   = '0;
                    n_left  = r_count - r_s;
                    n_up    = 1'b0;
                    n_count = r_count - r_s;
                    n_state = S_MOVE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

>>> design/deadline_sorted_timer_queue_core.sv
// ----------------------------------------------------------------------------
// deadline_sorted_timer_queue_core
// Bounded timer table kept sorted by deadline, with add, adjust, delete and
// tick commands.
// ----------------------------------------------------------------------------
// One command is handled at a time; o_stall stays high until its work is
// finished, while its result may still wait in the output register. Every
// access goes through the table memory, at most one read and one write per
// cycle. Add, adjust and delete run an id search over the table and then
// shift passes (adjust does two passes, add one, delete one). Tick reads
// the expired timers from the front, then does one shift pass over the
// remaining entries, and it takes longer if the output side stalls.
// ----------------------------------------------------------------------------
module deadline_sorted_timer_queue_core import dstq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  logic      i_valid,
    output logic      o_stall,
    output t_out_item o_item,
    output logic      o_valid,
    input  logic      i_stall
);

    t_ram_req  ram_req;
    t_entry    rd_data;
    t_emit     emit;
    logic      busy;
    logic      can_load;
    logic      in_xfer;
    logic      r_out_valid;
    t_out_item r_out_item;

    // input transfer only when the sequencer is idle
    assign in_xfer  = i_valid && !busy;
    assign o_stall  = busy;

    // output register slot is free after this edge
    assign can_load = !r_out_valid || !i_stall;

    dstq_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_xfer),
        .i_item     (i_item),
        .i_can_load (can_load),
        .i_rd_data  (rd_data),
        .o_ram_req  (ram_req),
        .o_emit     (emit),
        .o_busy     (busy)
    );

    dstq_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (can_load) begin
            r_out_valid <= emit.valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (can_load && emit.valid) begin
            r_out_item <= emit.res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the deadline-sorted timer queue core.
// ----------------------------------------------------------------------------
// A short table of directed commands is followed by randomised traffic built
// around a slowly advancing time base. A behavioural copy of the timer table
// predicts every result, and each output transfer is compared field by field
// with the oldest prediction. Idling on both sides is varied by phase, and
// one long output hold-off lets the core back up and stall its input.
// ----------------------------------------------------------------------------
module tb_top;
    import dstq_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 252;
    localparam int DRAIN_CYCLES = 64;

    // Directed table row
    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_dir_row;

    logic      i_clk;
    logic      i_rst_n;
    t_in_item  i_item;
    logic      i_valid;
    logic      o_stall;
    t_out_item o_item;
    logic      o_valid;
    logic      i_stall;

    // Behavioural copy of the timer table
    logic [31:0] tbl_deadline [MAX_TIMERS];
    logic [3:0]  tbl_ident    [MAX_TIMERS];
    int          tbl_count;

    // Outcomes of the command being predicted, and those still owed by the core
    t_out_item cmd_outcome [RESULT_LIMIT];
    int        cmd_outcome_n;
    t_out_item timer_outcomes [$];

    t_dir_row directed_rows [$];

    int          tx_idle_pct;
    int          rx_stall_pct;
    int          hold_requests;
    int          errors;
    int          commands_sent;
    int          results_seen;
    int          expiries_seen;
    int          peak_count;
    int          cycle_count;
    logic [31:0] clock_secs;

    deadline_sorted_timer_queue_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_item  (o_item),
        .o_valid (o_valid),
        .i_stall (i_stall)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Slot holding this id, or tbl_count if absent
    function automatic int find_timer(logic [3:0] id);
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_ident[i] == id) return i;
        end
        return tbl_count;
    endfunction

    function automatic void drop_slot(int pos);
        for (int i = pos; i + 1 < tbl_count; i++) begin
            tbl_deadline[i] = tbl_deadline[i + 1];
            tbl_ident[i]    = tbl_ident[i + 1];
        end
        tbl_count--;
    endfunction

    // Insert after every entry due at or before dl; caller checks for room
    function automatic void place_timer(logic [3:0] id, logic [31:0] dl);
        int pos;
        pos = 0;
        while (pos < tbl_count && tbl_deadline[pos] <= dl) pos++;
        for (int i = tbl_count; i > pos; i--) begin
            tbl_deadline[i] = tbl_deadline[i - 1];
            tbl_ident[i]    = tbl_ident[i - 1];
        end
        tbl_deadline[pos] = dl;
        tbl_ident[pos]    = id;
        tbl_count++;
    endfunction

    function automatic void log_outcome(t_status st, logic [3:0] id, logic fin);
        cmd_outcome[cmd_outcome_n] = '{status: st, expired_id: id, last: fin};
        cmd_outcome_n++;
    endfunction

    // Apply one command to the table copy and record the results it causes
    function automatic void run_timer_command(t_in_item it);
        int pos;
        cmd_outcome_n = 0;
        case (it.command)
            CMD_ADD: begin
                if (find_timer(it.timer_id) < tbl_count) begin
                    log_outcome(ST_PRESENT, 4'd0, 1'b1);
                end else if (tbl_count >= MAX_TIMERS) begin
                    log_outcome(ST_FULL, 4'd0, 1'b1);
                end else begin
                    place_timer(it.timer_id, it.deadline);
                    log_outcome(ST_DONE, 4'd0, 1'b1);
                end
            end
            CMD_ADJUST, CMD_DELETE: begin
                pos = find_timer(it.timer_id);
                if (pos >= tbl_count) begin
                    log_outcome(ST_NOT_FOUND, 4'd0, 1'b1);
                end else begin
                    drop_slot(pos);
                    if (it.command == CMD_ADJUST) place_timer(it.timer_id, it.deadline);
                    log_outcome(ST_DONE, 4'd0, 1'b1);
                end
            end
            default: begin
                while (cmd_outcome_n < RESULT_LIMIT && tbl_count > 0 &&
                       tbl_deadline[0] <= it.now) begin
                    log_outcome(ST_EXPIRED, tbl_ident[0], 1'b0);
                    drop_slot(0);
                end
                if (cmd_outcome_n == 0) log_outcome(ST_NONE_DUE, 4'd0, 1'b1);
                else cmd_outcome[cmd_outcome_n - 1].last = 1'b1;
            end
        endcase
    endfunction

    function automatic void add_row(t_cmd c, logic [3:0] id, logic [31:0] dl,
                                    logic [31:0] nw, bit typed, t_status st);
        t_dir_row r;
        r.item  = '{command: c, timer_id: id, deadline: dl, now: nw};
        r.typed = typed;
        r.want  = '{status: st, expired_id: 4'd0, last: 1'b1};
        directed_rows.push_back(r);
    endfunction

    // Mostly well-formed traffic around clock_secs, with some full-range noise
    function automatic t_in_item make_random_command();
        t_in_item it;
        int roll;
        roll        = $urandom_range(99);
        it.timer_id = 4'($urandom_range(15));
        it.deadline = clock_secs + 32'($urandom_range(60));
        it.now      = $urandom;
        if (roll < 10) begin
            it.command  = t_cmd'($urandom_range(3));
            it.deadline = $urandom;
            return it;
        end
        if (roll < 45) it.command = CMD_ADD;
        else if (roll < 58) it.command = CMD_ADJUST;
        else if (roll < 68) it.command = CMD_DELETE;
        else it.command = CMD_TICK;
        // Adjust and delete mostly aim at a timer that is held
        if ((it.command == CMD_ADJUST || it.command == CMD_DELETE) && tbl_count > 0 &&
            $urandom_range(99) < 80)
            it.timer_id = tbl_ident[$urandom_range(tbl_count - 1)];
        if (it.command == CMD_TICK) begin
            clock_secs = clock_secs + 32'($urandom_range(25));
            it.now     = ($urandom_range(99) < 90) ? clock_secs : $urandom;
        end
        if ($urandom_range(99) < 8) it.deadline = $urandom;
        return it;
    endfunction

    // One input transfer, after a random idle gap; predict on acceptance
    task automatic send_command(t_in_item it, bit typed, t_out_item want);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_item  <= it;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        run_timer_command(it);
        if (typed) timer_outcomes.push_back(want);
        else for (int k = 0; k < cmd_outcome_n; k++) timer_outcomes.push_back(cmd_outcome[k]);
        if (tbl_count > peak_count) peak_count = tbl_count;
        commands_sent++;
    endtask

    // Output side: random stall, plus long hold-offs on request
    initial begin
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        i_stall     = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && hold_served != hold_requests) begin
                hold_left = HOLD_CYCLES;
                hold_served++;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    // Compare every output transfer with the oldest outstanding outcome
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (o_item.status == ST_EXPIRED) expiries_seen++;
            if (timer_outcomes.size() == 0) begin
                $error("unexpected result: status %0d, expired_id %0d, last %0d",
                       o_item.status, o_item.expired_id, o_item.last);
                errors++;
            end else begin
                want = timer_outcomes.pop_front();
                if (o_item.status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, o_item.status);
                    errors++;
                end
                if (o_item.expired_id !== want.expired_id) begin
                    $error("expired_id mismatch: expected %0d, actual %0d",
                           want.expired_id, o_item.expired_id);
                    errors++;
                end
                if (o_item.last !== want.last) begin
                    $error("last mismatch: expected %0d, actual %0d",
                           want.last, o_item.last);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding",
                 cycle_count, timer_outcomes.size());
        $display("TB_ERROR");
        $finish;
    end

    // Main sequence
    initial begin
        t_out_item none;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_item        = '0;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        hold_requests = 0;
        errors        = 0;
        commands_sent = 0;
        results_seen  = 0;
        expiries_seen = 0;
        peak_count    = 0;
        tbl_count     = 0;
        clock_secs    = 32'd1000;
        none          = '0;

        // Directed: empty table, error codes, extremes, reordering on adjust
        add_row(CMD_TICK,   4'd0,  32'd0,          32'd0, 1'b1, ST_NONE_DUE);
        add_row(CMD_DELETE, 4'd5,  32'd0,          32'd0, 1'b1, ST_NOT_FOUND);
        add_row(CMD_ADJUST, 4'd0,  32'd9,          32'd0, 1'b1, ST_NOT_FOUND);
        add_row(CMD_ADD,    4'd0,  32'hFFFF_FFFF,  32'd0, 1'b1, ST_DONE);
        add_row(CMD_ADD,    4'd0,  32'd0,          32'd0, 1'b1, ST_PRESENT);
        add_row(CMD_ADD,    4'd15, 32'd0,          32'd0, 1'b1, ST_DONE);
        add_row(CMD_ADD,    4'd3,  32'd100,        32'd0, 1'b1, ST_DONE);
        add_row(CMD_ADJUST, 4'd3,  32'd200,        32'd0, 1'b0, ST_DONE);
        // Adjust to an earlier deadline moves the timer forward
        add_row(CMD_ADJUST, 4'd0,  32'd50,         32'd0, 1'b0, ST_DONE);
        add_row(CMD_TICK,   4'd0,  32'd0,          32'd99, 1'b0, ST_DONE);
        // Fill the table with repeated deadlines to check arrival order
        for (int id = 0; id < MAX_TIMERS; id++) begin
            if (id != 3)
                add_row(CMD_ADD, 4'(id), (id % 2) ? 32'hFFFF_FFFF : 32'd1024,
                        32'd0, 1'b0, ST_DONE);
        end
        // A held id is reported before a full table
        add_row(CMD_ADD,    4'd3,  32'd0,          32'd0, 1'b1, ST_PRESENT);
        add_row(CMD_TICK,   4'd0,  32'd0,  32'hFFFF_FFFF, 1'b0, ST_DONE);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_command(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);

        // Random traffic across idling phases; the first starts with a long hold-off
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  hold_requests++; end
                1: begin tx_idle_pct = 86; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 86; end
                default: begin tx_idle_pct = 32; rx_stall_pct = 32; end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 4; n++)
                send_command(make_random_command(), 1'b0, none);
        end

        // Drain
        i_valid      <= 1'b0;
        rx_stall_pct = 0;
        while (timer_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d commands (%0d directed) and %0d results in %0d cycles",
                 commands_sent, directed_rows.size(), results_seen, cycle_count);
        $display("Timers expired: %0d, peak table occupancy: %0d", expiries_seen, peak_count);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
